>>> design/olib_pkg.sv
// Shared definitions for the ordered list block: command and status codes,
// beat field widths and the per-cell control bundle. No dependencies.
package olib_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	localparam int OP_W      = 2;
	localparam int FIELD_ID_W = 16;
	localparam int PAY_W     = 64;
	localparam int STATUS_W  = 3;

	localparam int IN_BITS   = OP_W + FIELD_ID_W + PAY_W + FIELD_ID_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = STATUS_W + FIELD_ID_W + PAY_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_APPENDED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_AT_HEAD     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSIDE      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY_NOKEY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_KEY_MISSING = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;
	localparam logic [STATUS_W-1:0] ST_ENTRY       = 3'd6;
	localparam logic [STATUS_W-1:0] ST_LIST_EMPTY  = 3'd7;

	typedef struct packed {
		logic rot;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

>>> design/olib_cell.sv
// One list slot of the cell row: holds an id and a payload word.
// Loads a new entry, takes its lower neighbor, or takes its upper neighbor.
// Depends on olib_pkg.
module olib_cell #(
	parameter int KEY_W = 16
) (
	input  logic                    clk,
	input  olib_pkg::cell_ctl_t     ctl,
	input  logic [KEY_W-1:0]        new_id,
	input  logic [olib_pkg::PAY_W-1:0] new_payload,
	input  logic [KEY_W-1:0]        prev_id,
	input  logic [olib_pkg::PAY_W-1:0] prev_payload,
	input  logic [KEY_W-1:0]        next_id,
	input  logic [olib_pkg::PAY_W-1:0] next_payload,
	output logic [KEY_W-1:0]        id,
	output logic [olib_pkg::PAY_W-1:0] payload
);
	import olib_pkg::*;

	logic [KEY_W-1:0] id_q;
	logic [PAY_W-1:0] payload_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q      <= new_id;
			payload_q <= new_payload;
		end else if (ctl.shift) begin
			id_q      <= prev_id;
			payload_q <= prev_payload;
		end else if (ctl.rot) begin
			id_q      <= next_id;
			payload_q <= next_payload;
		end
	end

	assign id      = id_q;
	assign payload = payload_q;

endmodule

>>> design/ordered_list_insert_before_key.sv
// Ordered list store: top level with the command sequencer and the cell row.
// Append, full and empty results are registered straight from the idle state. Insert-before
// rotates the whole row once past the head cell to find the key, then shifts the new
// entry in. Readout rotates the whole row once, one entry a cycle while the output is
// taken. Reset clears the count; entry contents stay unknown.
module ordered_list_insert_before_key #(
	parameter int CAPACITY = olib_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = olib_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[1:0], new_id[17:2], new_payload[81:18], key_id[97:82], zero pad above.
	input  logic [olib_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[2:0], entry_id[18:3], entry_payload[82:19], zero pad above.
	output logic [olib_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import olib_pkg::*;

	localparam int KEY_W = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int PW    = $clog2(CAPACITY);

	typedef enum logic [1:0] {IDLE, SCAN, SHIFT, READ} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [PW-1:0]     step_q;
	logic [PW-1:0]     pos_q;
	logic              found_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  new_id_q;
	logic [PAY_W-1:0]  new_pay_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [KEY_W-1:0]  out_id_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic              out_last_q;

	logic [OP_W-1:0]   in_op;
	logic [KEY_W-1:0]  in_new_id;
	logic [PAY_W-1:0]  in_pay;
	logic [KEY_W-1:0]  in_key;

	logic [KEY_W-1:0]  cell_id  [CAPACITY];
	logic [PAY_W-1:0]  cell_pay [CAPACITY];
	cell_ctl_t         cell_ctl [CAPACITY];

	logic slot_free, accept, rot, step_last, step_used, head_match, read_adv;
	logic [KEY_W-1:0] load_id;
	logic [PAY_W-1:0] load_pay;

	assign in_op     = s_tdata[OP_W-1:0];
	assign in_new_id = s_tdata[OP_W +: KEY_W];
	assign in_pay    = s_tdata[OP_W + FIELD_ID_W +: PAY_W];
	assign in_key    = s_tdata[OP_W + FIELD_ID_W + PAY_W +: KEY_W];

	assign slot_free  = !out_valid_q || m_tready;
	assign s_tready   = (state_q == IDLE) && slot_free;
	assign accept     = s_tvalid && s_tready;
	assign step_last  = (step_q == PW'(CAPACITY - 1));
	assign step_used  = (CW'(step_q) < count_q);
	assign head_match = step_used && !found_q && (cell_id[0] == key_q);
	assign read_adv   = !step_used || slot_free;
	assign rot        = (state_q == SCAN) || ((state_q == READ) && read_adv);
	assign load_id    = (state_q == IDLE) ? in_new_id : new_id_q;
	assign load_pay   = (state_q == IDLE) ? in_pay : new_pay_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NX = (i + 1) % CAPACITY;
		localparam int PV = (i == 0) ? 0 : i - 1;

		always_comb begin
			cell_ctl[i].rot   = rot;
			cell_ctl[i].shift = (state_q == SHIFT) && (PW'(i) > pos_q);
			cell_ctl[i].load  = ((state_q == SHIFT) && (PW'(i) == pos_q)) ||
				(accept && (in_op == OP_APPEND) && (count_q == CW'(i)));
		end

		olib_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[i]),
			.new_id      (load_id),
			.new_payload (load_pay),
			.prev_id     (cell_id[PV]),
			.prev_payload(cell_pay[PV]),
			.next_id     (cell_id[NX]),
			.next_payload(cell_pay[NX]),
			.id          (cell_id[i]),
			.payload     (cell_pay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			step_q      <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					step_q  <= '0;
					found_q <= 1'b0;
					if (accept) begin
						key_q     <= in_key;
						new_id_q  <= in_new_id;
						new_pay_q <= in_pay;
						out_id_q  <= '0;
						out_pay_q <= '0;
						out_last_q <= 1'b1;
						case (in_op)
							OP_APPEND: begin
								out_valid_q <= 1'b1;
								if (count_q == CW'(CAPACITY)) begin
									out_status_q <= ST_FULL;
								end else begin
									out_status_q <= ST_APPENDED;
									count_q      <= count_q + CW'(1);
								end
							end
							OP_INSERT: begin
								if (count_q == '0) begin
									out_valid_q  <= 1'b1;
									out_status_q <= ST_EMPTY_NOKEY;
								end else if (count_q == CW'(CAPACITY)) begin
									out_valid_q  <= 1'b1;
									out_status_q <= ST_FULL;
								end else begin
									state_q <= SCAN;
								end
							end
							OP_READ: begin
								if (count_q == '0) begin
									out_valid_q  <= 1'b1;
									out_status_q <= ST_LIST_EMPTY;
								end else begin
									state_q <= READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SCAN: begin
					step_q <= step_q + PW'(1);
					if (head_match) begin
						found_q <= 1'b1;
						pos_q   <= step_q;
					end
					if (step_last) begin
						if (found_q || head_match) begin
							state_q <= SHIFT;
						end else begin
							state_q      <= IDLE;
							out_valid_q  <= 1'b1;
							out_status_q <= ST_KEY_MISSING;
							out_id_q     <= '0;
							out_pay_q    <= '0;
							out_last_q   <= 1'b1;
						end
					end
				end
				SHIFT: begin
					state_q      <= IDLE;
					count_q      <= count_q + CW'(1);
					out_valid_q  <= 1'b1;
					out_status_q <= (pos_q == '0) ? ST_AT_HEAD : ST_INSIDE;
					out_id_q     <= '0;
					out_pay_q    <= '0;
					out_last_q   <= 1'b1;
				end
				READ: begin
					if (read_adv) begin
						step_q <= step_q + PW'(1);
						if (step_used) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_ENTRY;
							out_id_q     <= cell_id[0];
							out_pay_q    <= cell_pay[0];
							out_last_q   <= (CW'(CW'(step_q) + CW'(1)) == count_q);
						end
						if (step_last) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_pay_q,
		FIELD_ID_W'(out_id_q), out_status_q};

endmodule
